@@ rtl/unison_wavetable_oscillator_core_defines.svh @@
// Assertion macros shared by the oscillator RTL.
// Uses the clock and reset names of the module that expands them.
`ifndef UNISON_WAVETABLE_OSCILLATOR_CORE_DEFINES_SVH
`define UNISON_WAVETABLE_OSCILLATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define UWO_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define UWO_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/uwo_pkg.sv @@
// Constants, codes and types of the unison wavetable oscillator.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package uwo_pkg;
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int LEN_BITS    = ADDR_BITS + 1;
   localparam int MAX_VOICES  = 8;
   localparam int VOICE_BITS  = $clog2(MAX_VOICES);
   localparam int NV_BITS     = VOICE_BITS + 1;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;
   localparam int SPAN_BITS   = LEN_BITS + FRAC_BITS;
   localparam int PHASE_BITS  = SPAN_BITS - 1;
   localparam int FACTOR_BITS = 32;
   localparam int PROD_BITS   = 58;
   localparam int INC_BITS    = PROD_BITS - 30;
   localparam int TERM_BITS   = SAMPLE_BITS + FRAC_BITS + 2;
   localparam int ACC_BITS    = TERM_BITS + VOICE_BITS;
   localparam int QUO_BITS    = ACC_BITS - FRAC_BITS;
   localparam int MOD_STEPS   = LEN_BITS;
   localparam int STEP_BITS   = 5;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_TABLE = 2'd1;
   localparam logic [1:0] OP_RATIO = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [2:0] REG_BASE   = 3'd0;
   localparam logic [2:0] REG_DETUNE = 3'd1;
   localparam logic [2:0] REG_VOICES = 3'd2;
   localparam logic [2:0] REG_INTERP = 3'd3;
   localparam logic [2:0] REG_LENGTH = 3'd4;

   localparam logic [3:0] CMD_NONE   = 4'd0;
   localparam logic [3:0] CMD_ACCEPT = 4'd1;
   localparam logic [3:0] CMD_PROD   = 4'd2;
   localparam logic [3:0] CMD_MUL    = 4'd3;
   localparam logic [3:0] CMD_ADD    = 4'd4;
   localparam logic [3:0] CMD_SUB    = 4'd5;
   localparam logic [3:0] CMD_MOD    = 4'd6;
   localparam logic [3:0] CMD_RDA    = 4'd7;
   localparam logic [3:0] CMD_RDB    = 4'd8;
   localparam logic [3:0] CMD_MULT   = 4'd9;
   localparam logic [3:0] CMD_ACC    = 4'd10;
   localparam logic [3:0] CMD_DIVI   = 4'd11;
   localparam logic [3:0] CMD_DIV    = 4'd12;
   localparam logic [3:0] CMD_FIN    = 4'd13;

   typedef struct packed {
      logic [3:0]            op;
      logic [VOICE_BITS-1:0] voice;
      logic [3:0]            shift;
   } cmd_type;

   typedef struct packed {
      logic req_tick;
      logic len_zero;
      logic ph_ge_span;
      logic voice_last;
      logic out_free;
   } status_type;
endpackage

@@ rtl/uwo_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module uwo_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/uwo_datapath.sv @@
// Datapath of the oscillator: registers, voice state, arithmetic and output word.
// Depends on uwo_pkg and uwo_ram; driven by commands from uwo_ctrl.
`timescale 1ns / 1ps
module uwo_datapath import uwo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [1:0]  req_opcode,
   input  logic [9:0]  req_target,
   input  logic signed [15:0] req_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output logic [31:0] csr_rdata
);
   logic [25:0]        base_ff;
   logic signed [15:0] detune_ff;
   logic [3:0]         voices_ff;
   logic               interp_ff;
   logic [10:0]        length_ff;

   logic [PHASE_BITS-1:0]  phase_ff [MAX_VOICES];
   logic signed [15:0]     ratio_ff [MAX_VOICES];
   logic signed [31:0]     prod_ff;
   logic [INC_BITS-1:0]    inc_ff;
   logic [SPAN_BITS-1:0]   ph_ff;
   logic signed [15:0]     a_ff;
   logic signed [TERM_BITS-1:0] ta_ff, tb_ff;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic [QUO_BITS-1:0]    u_ff;
   logic [3:0]             rem_ff;
   logic                   neg_ff;
   logic                   rsp_valid_ff;
   logic [15:0]            rsp_data_ff;

   logic [LEN_BITS-1:0]    len_eff;
   logic [NV_BITS-1:0]     nv_eff;
   logic [SPAN_BITS-1:0]   span;
   logic [31:0]            factor;
   logic [PROD_BITS-1:0]   product;
   logic [INC_BITS-1:0]    inc_clamped;
   logic [SPAN_BITS+10:0]  span_shift;
   logic [ADDR_BITS-1:0]   below;
   logic [LEN_BITS-1:0]    above_full;
   logic [ADDR_BITS-1:0]   above;
   logic [ADDR_BITS-1:0]   raddr;
   logic signed [15:0]     rdata;
   logic [FRAC_BITS-1:0]   frac;
   logic signed [ACC_BITS-1:0] term;
   logic [4:0]             rem_trial;
   logic                   rem_ge;
   logic signed [QUO_BITS-1:0] quotient;
   logic signed [15:0]     saturated;
   logic                   ram_we;

   assign len_eff = (length_ff > 11'(TABLE_DEPTH)) ? LEN_BITS'(TABLE_DEPTH) : length_ff;
   always_comb begin
      if (voices_ff == 4'd0) begin
         nv_eff = NV_BITS'(1);
      end else if (voices_ff > 4'(MAX_VOICES)) begin
         nv_eff = NV_BITS'(MAX_VOICES);
      end else begin
         nv_eff = voices_ff;
      end
   end
   assign span = {len_eff, {FRAC_BITS{1'b0}}};
   assign factor = 32'(33'sh40000000 + 33'(prod_ff));
   assign product = PROD_BITS'(base_ff) * PROD_BITS'(factor);
   assign inc_clamped = (inc_ff > INC_BITS'(span - 1'b1)) ? INC_BITS'(span - 1'b1) : inc_ff;
   assign span_shift = (SPAN_BITS+11)'(span) << cmd.shift;
   assign below = ph_ff[FRAC_BITS +: ADDR_BITS];
   assign above_full = LEN_BITS'(below) + 1'b1;
   assign above = (above_full >= len_eff) ? '0 : above_full[ADDR_BITS-1:0];
   assign raddr = (cmd.op == CMD_RDB) ? above : below;
   assign frac = ph_ff[FRAC_BITS-1:0];
   assign term = interp_ff ? (ACC_BITS'(ta_ff) + ACC_BITS'(tb_ff))
                           : ACC_BITS'(signed'({a_ff, {FRAC_BITS{1'b0}}}));
   assign rem_trial = {rem_ff, u_ff[QUO_BITS-1]};
   assign rem_ge = rem_trial >= 5'(nv_eff);
   assign quotient = neg_ff ? ~u_ff : u_ff;
   always_comb begin
      if (quotient > QUO_BITS'(32767)) begin
         saturated = 16'sh7fff;
      end else if (quotient < -QUO_BITS'(32768)) begin
         saturated = -16'sh8000;
      end else begin
         saturated = quotient[15:0];
      end
   end
   assign ram_we = (cmd.op == CMD_ACCEPT) && (req_opcode == OP_TABLE);

   uwo_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TABLE_DEPTH)) u_wave (
      .clock(clock), .we(ram_we), .waddr(req_target), .wdata(req_data),
      .raddr(raddr), .rdata(rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         detune_ff <= '0;
         voices_ff <= 4'd1;
         interp_ff <= 1'b1;
         length_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_BASE:   base_ff   <= csr_wdata[25:0];
            REG_DETUNE: detune_ff <= csr_wdata[15:0];
            REG_VOICES: voices_ff <= csr_wdata[3:0];
            REG_INTERP: interp_ff <= csr_wdata[0];
            REG_LENGTH: length_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BASE:   csr_rdata = 32'(base_ff);
         REG_DETUNE: csr_rdata = 32'(signed'(detune_ff));
         REG_VOICES: csr_rdata = 32'(voices_ff);
         REG_INTERP: csr_rdata = 32'(interp_ff);
         REG_LENGTH: csr_rdata = 32'(length_ff);
         default:    csr_rdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VOICES; i++) begin
            phase_ff[i] <= '0;
            ratio_ff[i] <= '0;
         end
      end else if (cmd.op == CMD_ACCEPT) begin
         if (req_opcode == OP_RATIO && req_target[9:VOICE_BITS] == '0) begin
            ratio_ff[req_target[VOICE_BITS-1:0]] <= req_data;
         end
         if (req_opcode == OP_CLEAR) begin
            for (int i = 0; i < MAX_VOICES; i++) begin
               phase_ff[i] <= '0;
            end
         end
      end else if (cmd.op == CMD_RDA) begin
         phase_ff[cmd.voice] <= ph_ff[PHASE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_ACCEPT: begin
            acc_ff <= '0;
            u_ff   <= '0;
            neg_ff <= 1'b0;
         end
         CMD_PROD: prod_ff <= ratio_ff[cmd.voice] * detune_ff;
         CMD_MUL:  inc_ff <= product[PROD_BITS-1:30];
         CMD_ADD:  ph_ff <= SPAN_BITS'(phase_ff[cmd.voice]) + SPAN_BITS'(inc_clamped);
         CMD_SUB: begin
            if (ph_ff >= span) begin
               ph_ff <= ph_ff - span;
            end
         end
         CMD_MOD: begin
            if ((SPAN_BITS+11)'(ph_ff) >= span_shift) begin
               ph_ff <= ph_ff - span_shift[SPAN_BITS-1:0];
            end
         end
         CMD_MULT: begin
            ta_ff <= TERM_BITS'(a_ff)
                   * TERM_BITS'(signed'({1'b0, 17'((1 << FRAC_BITS) - frac)}));
            tb_ff <= TERM_BITS'(rdata) * TERM_BITS'(signed'({2'b0, frac}));
         end
         CMD_ACC:  acc_ff <= acc_ff + term;
         CMD_DIVI: begin
            neg_ff <= acc_ff[ACC_BITS-1];
            u_ff   <= acc_ff[ACC_BITS-1] ? ~acc_ff[ACC_BITS-1:FRAC_BITS]
                                         : acc_ff[ACC_BITS-1:FRAC_BITS];
            rem_ff <= '0;
         end
         CMD_DIV: begin
            u_ff   <= {u_ff[QUO_BITS-2:0], rem_ge};
            rem_ff <= rem_ge ? 4'(rem_trial - 5'(nv_eff)) : rem_trial[3:0];
         end
         default: ;
      endcase
      if (cmd.op == CMD_RDB) begin
         a_ff <= rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == CMD_FIN) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_FIN) begin
         rsp_data_ff <= saturated;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign status.req_tick   = (req_opcode == OP_TICK);
   assign status.len_zero   = (length_ff == '0);
   assign status.ph_ge_span = (ph_ff >= span);
   assign status.voice_last = (NV_BITS'(cmd.voice) == nv_eff - 1'b1);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;
endmodule

@@ rtl/uwo_ctrl.sv @@
// Sequencer of the oscillator: walks the voices, the phase reduction and the divider.
// Depends on uwo_pkg; commands uwo_datapath.
`timescale 1ns / 1ps
module uwo_ctrl import uwo_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PROD = 4'd1;
   localparam logic [3:0] S_MUL  = 4'd2;
   localparam logic [3:0] S_ADD  = 4'd3;
   localparam logic [3:0] S_SUB  = 4'd4;
   localparam logic [3:0] S_CHK  = 4'd5;
   localparam logic [3:0] S_MOD  = 4'd6;
   localparam logic [3:0] S_RDA  = 4'd7;
   localparam logic [3:0] S_RDB  = 4'd8;
   localparam logic [3:0] S_MULT = 4'd9;
   localparam logic [3:0] S_ACC  = 4'd10;
   localparam logic [3:0] S_DIVI = 4'd11;
   localparam logic [3:0] S_DIV  = 4'd12;
   localparam logic [3:0] S_FIN  = 4'd13;

   logic [3:0]            state_ff, state_in;
   logic [VOICE_BITS-1:0] voice_ff, voice_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      voice_in  = voice_ff;
      step_in   = step_ff;
      cmd.op    = CMD_NONE;
      cmd.voice = voice_ff;
      cmd.shift = step_ff[3:0];
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op = CMD_ACCEPT;
               if (status.req_tick) begin
                  voice_in = '0;
                  state_in = status.len_zero ? S_FIN : S_PROD;
               end
            end
         end
         S_PROD: begin
            cmd.op = CMD_PROD;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op = CMD_MUL;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.op = CMD_ADD;
            state_in = S_SUB;
         end
         S_SUB: begin
            cmd.op = CMD_SUB;
            state_in = S_CHK;
         end
         S_CHK: begin
            step_in = STEP_BITS'(MOD_STEPS - 1);
            state_in = status.ph_ge_span ? S_MOD : S_RDA;
         end
         S_MOD: begin
            cmd.op = CMD_MOD;
            if (step_ff == '0) begin
               state_in = S_RDA;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_RDA: begin
            cmd.op = CMD_RDA;
            state_in = S_RDB;
         end
         S_RDB: begin
            cmd.op = CMD_RDB;
            state_in = S_MULT;
         end
         S_MULT: begin
            cmd.op = CMD_MULT;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = CMD_ACC;
            if (status.voice_last) begin
               state_in = S_DIVI;
            end else begin
               voice_in = voice_ff + 1'b1;
               state_in = S_PROD;
            end
         end
         S_DIVI: begin
            cmd.op = CMD_DIVI;
            step_in = STEP_BITS'(QUO_BITS - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = CMD_DIV;
            if (step_ff == '0) begin
               state_in = S_FIN;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.op = CMD_FIN;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         voice_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         voice_ff <= voice_in;
         step_ff  <= step_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
endmodule

@@ rtl/unison_wavetable_oscillator_core.sv @@
// Unison wavetable oscillator. A tick word with a zero table length is accepted and
// emitted directly; otherwise the sequencer walks each active voice (with an extra
// modulo reduction when a phase lies beyond a shrunken table), then the averaging
// divider, and the result waits while the output is stalled. Table, ratio and clear
// words are accepted without leaving idle.
// Depends on uwo_pkg, uwo_ctrl, uwo_datapath.
`timescale 1ns / 1ps
`include "unison_wavetable_oscillator_core_defines.svh"
module unison_wavetable_oscillator_core import uwo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // target_index[9:0], data_word[25:10], zeros above
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // sample_out[15:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   uwo_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .status(status), .cmd(cmd)
   );

   uwo_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_opcode(req_tuser), .req_target(req_tdata[9:0]), .req_data(req_tdata[25:10]),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_write(csr_write), .csr_index(csr_paddr[4:2]), .csr_wdata(csr_pwdata),
      .csr_rdata(csr_prdata)
   );

   `UWO_ASSERT_NEXT(a_load_stays_idle, req_tvalid && req_tready && req_tuser != OP_TICK, req_tready, "load word left idle")
   `UWO_ASSERT_NEXT(a_tick_busy, req_tvalid && req_tready && req_tuser == OP_TICK, !req_tready, "tick word did not start")
   `UWO_ASSERT_NOW(a_result_then_idle, $rose(rsp_tvalid), req_tready, "result issued while busy")
endmodule

@@ tb/unison_wavetable_oscillator_core_tb.sv @@
// Self-checking testbench for the unison wavetable oscillator core.
// Drives table, ratio, clear and tick words, predicts every averaged sample and
// compares it with the block's output. Depends on uwo_pkg and the core RTL.
`timescale 1ns / 1ps
module unison_wavetable_oscillator_core_tb;
   import uwo_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   unison_wavetable_oscillator_core dut (.*);

   // Predictor state.
   logic signed [15:0] wave_mem [TABLE_DEPTH];
   bit                 wave_written [TABLE_DEPTH];
   logic [63:0]        phase_acc [MAX_VOICES];
   logic signed [15:0] ratio_mem [MAX_VOICES];
   logic [25:0]        base_inc;
   logic signed [15:0] detune;
   logic [3:0]         voices;
   logic               interp;
   logic [10:0]        tab_len;

   logic [15:0] sample_queue [$];
   int          error_count;
   int          samples_seen;
   int          ticks_sent;
   bit          idle_on;
   bit          hold_rsp;
   int          hold_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #200ms;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   function automatic logic [15:0] predict_tick();
      logic [63:0]  len;
      logic [63:0]  span;
      logic [63:0]  inc;
      logic [63:0]  ph;
      logic [63:0]  below;
      logic [63:0]  above;
      int           nv;
      longint       factor;
      longint       frac;
      longint       sum;
      longint       div;
      longint       avg;
      sum = 0;
      if (tab_len == 0) return 16'd0;
      len = (tab_len > TABLE_DEPTH) ? TABLE_DEPTH : tab_len;
      nv = (voices == 0) ? 1 : ((voices > MAX_VOICES) ? MAX_VOICES : voices);
      span = len << FRAC_BITS;
      for (int i = 0; i < nv; i++) begin
         factor = (longint'(1) << 30) + longint'(ratio_mem[i]) * longint'(detune);
         inc = (64'(base_inc) * 64'(factor)) >> 30;
         if (inc > span - 1) inc = span - 1;
         ph = phase_acc[i] + inc;
         if (ph >= span) ph -= span;
         if (ph >= span) ph %= span;
         phase_acc[i] = ph;
      end
      for (int i = 0; i < nv; i++) begin
         ph = phase_acc[i];
         below = ph >> FRAC_BITS;
         if (interp) begin
            above = below + 1;
            if (above >= len) above = 0;
            frac = longint'(ph & 64'hFFFF);
            sum += longint'(wave_mem[below]) * ((longint'(1) << FRAC_BITS) - frac)
                 + longint'(wave_mem[above]) * frac;
         end else begin
            sum += longint'(wave_mem[below]) * (longint'(1) << FRAC_BITS);
         end
      end
      div = longint'(nv) << FRAC_BITS;
      avg = sum / div;
      if ((sum % div) != 0 && sum < 0) avg -= 1;
      if (avg > 32767) avg = 32767;
      if (avg < -32768) avg = -32768;
      return 16'(avg);
   endfunction

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(index) << 2;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_BASE:   base_inc = value[25:0];
         REG_DETUNE: detune   = value[15:0];
         REG_VOICES: voices   = value[3:0];
         REG_INTERP: interp   = value[0];
         REG_LENGTH: tab_len  = value[10:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [25:0] b, input logic [15:0] d, input logic [3:0] v,
                            input logic i, input logic [10:0] l);
      csr_write(REG_BASE, 32'(b));
      csr_write(REG_DETUNE, 32'(d));
      csr_write(REG_VOICES, 32'(v));
      csr_write(REG_INTERP, 32'(i));
      csr_write(REG_LENGTH, 32'(l));
   endtask

   task automatic drain();
      while (sample_queue.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   // Sends one word; the prediction is made when the word is accepted.
   task automatic send_word(input logic [1:0] op, input logic [9:0] idx,
                            input logic [15:0] data);
      if (idle_on) begin
         while ($urandom_range(99) < 13) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, data, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (op)
         OP_TABLE: begin
            wave_mem[idx] = data;
            wave_written[idx] = 1'b1;
         end
         OP_RATIO: if (idx < MAX_VOICES) ratio_mem[idx] = data;
         OP_CLEAR: foreach (phase_acc[i]) phase_acc[i] = 0;
         default: begin
            sample_queue.push_back(predict_tick());
            ticks_sent++;
         end
      endcase
      req_tvalid <= 1'b0;
   endtask

   // Fills the first n table entries with random samples (extremes included).
   task automatic fill_table(input int n);
      logic [15:0] v;
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(7))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            default: v = 16'($urandom);
         endcase
         send_word(OP_TABLE, 10'(k), v);
      end
   endtask

   task automatic random_ratios();
      for (int k = 0; k < MAX_VOICES; k++) send_word(OP_RATIO, 10'(k), 16'($urandom));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         samples_seen++;
         if (sample_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %h", rsp_tdata));
         end else begin
            if (rsp_tdata !== sample_queue[0])
               report_mismatch($sformatf("sample %h, predicted %h", rsp_tdata,
                                         sample_queue[0]));
            void'(sample_queue.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= idle_on ? ($urandom_range(99) >= 13) : 1'b1;
      end
   end

   task automatic test_directed();
      idle_on = 0;
      send_word(OP_TICK, 10'd0, 16'd0);                     // zero table length
      fill_table(8);
      send_word(OP_TABLE, 10'd1023, 16'h7FFF);
      wave_written[1023] = 1;
      send_word(OP_RATIO, 10'd0, 16'h7FFF);
      send_word(OP_RATIO, 10'd1, 16'h8000);
      send_word(OP_RATIO, 10'd9, 16'h1234);                  // voice out of range
      drain();
      configure(26'h3FFFFFF, 16'h7FFF, 4'd2, 1'b1, 11'd8);  // increment clamp
      send_word(OP_TICK, 10'd0, 16'd0);
      send_word(OP_TICK, 10'h3FF, 16'hFFFF);
      drain();
      configure(26'h18000, 16'h8000, 4'd0, 1'b0, 11'd8);    // zero voices, truncation
      send_word(OP_TICK, 10'd0, 16'd0);
      send_word(OP_CLEAR, 10'd0, 16'd0);
      send_word(OP_TICK, 10'd0, 16'd0);
      drain();
      configure(26'h28000, 16'h4000, 4'd15, 1'b1, 11'd8);   // voices above limit
      repeat (4) send_word(OP_TICK, 10'd0, 16'd0);
      drain();
      configure(26'h0, 16'h4000, 4'd1, 1'b1, 11'd3);        // shrunken table
      send_word(OP_TICK, 10'd0, 16'd0);
      send_word(OP_TICK, 10'd0, 16'd0);
      drain();
   endtask

   task automatic test_random_phases();
      int len;
      for (int phase = 0; phase < 10; phase++) begin
         len = (phase == 9) ? 1024 : ((phase == 0) ? 1 : $urandom_range(2, 40));
         fill_table(len);
         random_ratios();
         drain();
         configure(26'($urandom_range(0, 32'(len) << 17)), 16'($urandom),
                   4'($urandom_range(0, 9)), 1'($urandom), 11'(len));
         idle_on = (phase != 3);
         for (int k = 0; k < 40; k++) begin
            case ($urandom_range(19))
               0: send_word(OP_TABLE, 10'($urandom_range(len - 1)), 16'($urandom));
               1: send_word(OP_RATIO, 10'($urandom), 16'($urandom));
               2: send_word(OP_CLEAR, 10'($urandom), 16'($urandom));
               default: send_word(OP_TICK, 10'($urandom), 16'($urandom));
            endcase
         end
         drain();
      end
   endtask

   task automatic test_backpressure();
      configure(26'h12345, 16'h2000, 4'd8, 1'b1, 11'd16);
      idle_on = 1;
      hold_cycles = 3000;
      for (int k = 0; k < 20; k++) send_word(OP_TICK, 10'd0, 16'd0);
      drain();
      // The sender waits for all samples before every further tick.
      for (int k = 0; k < 10; k++) begin
         send_word(OP_TICK, 10'd0, 16'd0);
         while (sample_queue.size() != 0) @(posedge clock);
      end
      drain();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      error_count = 0;
      samples_seen = 0;
      ticks_sent  = 0;
      idle_on     = 0;
      hold_rsp    = 0;
      hold_cycles = 0;
      base_inc = 0;
      detune   = 0;
      voices   = 1;
      interp   = 1;
      tab_len  = 0;
      foreach (phase_acc[i]) phase_acc[i] = 0;
      foreach (ratio_mem[i]) ratio_mem[i] = 0;
      foreach (wave_mem[i]) wave_mem[i] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_phases();
      test_backpressure();

      $display("Covered %0d ticks with %0d samples checked across table, ratio, clear,",
               ticks_sent, samples_seen);
      $display("voice count, detune, interpolation and table length settings.");
      if (error_count == 0 && sample_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
